FILE: hw/rtl/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared constants, widths and the CORDIC arctangent table for the haversine
// distance pipeline.
// ----------------------------------------------------------------------------
package hvd_pkg;

	localparam int DEG_FRAC_BITS = 20;
	localparam int QB            = 40;

	// magnitude width into the radian converter
	localparam int MW  = 28;
	// radian angle width (Q40, at most pi)
	localparam int QW  = 42;
	// CORDIC datapath width (signed Q40)
	localparam int CW  = 44;
	// clamped sine or cosine width
	localparam int VW  = 42;
	// square root result width
	localparam int SQW = 41;
	// reciprocal of 45 for the exact divide of a 48-bit value
	localparam int NW  = 48;
	localparam int RCW = 49;

	localparam logic [26:0] LAT_MAX = 27'(90 << DEG_FRAC_BITS);
	localparam logic [27:0] LON_MAX = 28'(180 << DEG_FRAC_BITS);

	localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
	localparam logic [63:0] PI4_Q62 = 64'h3243F6A8885A308D;
	localparam logic [39:0] GAIN_Q40 = 40'd667681663043;
	localparam logic [RCW-1:0] RECIP45 = RCW'(((64'd1 << 54) + 64'd44) / 64'd45);

	localparam logic [23:0] RADIUS_RESET = 24'd6371000;

	typedef enum logic {
		REG_RADIUS = 1'b0,
		REG_NONE   = 1'b1
	} reg_idx_t;

	typedef logic signed [CW-1:0] cw_t;

	// atan(2^-i) in Q40, built from the integer series and rounded
	function automatic logic [63:0] atan_q40(input int unsigned i);
		logic [63:0] acc;
		logic [63:0] term;
		int unsigned k;
		acc = 64'd0;
		if (i == 0) begin
			acc = PI4_Q62;
		end else begin
			for (k = 0; i * (2 * k + 1) <= 62; k++) begin
				term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
				if (k[0]) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
		end
		return (acc + (64'd1 << 21)) >> 22;
	endfunction

endpackage

FILE: hw/rtl/hvd_mul.sv
// ----------------------------------------------------------------------------
// hvd_mul
// Two-stage unsigned multiplier: 32x32 partial products, then their sum.
// ----------------------------------------------------------------------------
module hvd_mul #(
	parameter int WA = 32,
	parameter int WB = 32,
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_i,
	input  logic [SW-1:0]    side_i,
	input  logic [WA-1:0]    a,
	input  logic [WB-1:0]    b,
	output logic             vld_o,
	output logic [SW-1:0]    side_o,
	output logic [WA+WB-1:0] p
);

	localparam int NA = (WA + 31) / 32;
	localparam int NB = (WB + 31) / 32;
	localparam int AP = NA * 32;
	localparam int BP = NB * 32;
	localparam int WP = WA + WB;

	logic [AP-1:0] ap;
	logic [BP-1:0] bp;
	logic [63:0]   pp_s1 [NA*NB];
	logic          vld_s1, vld_s2;
	logic [SW-1:0] side_s1, side_s2;
	logic [WP-1:0] sum;
	logic [WP-1:0] p_s2;

	assign ap = AP'(a);
	assign bp = BP'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i*NB+j] <= 64'(ap[i*32 +: 32]) * 64'(bp[j*32 +: 32]);
				end
			end
			side_s1 <= side_i;
			side_s2 <= side_s1;
			p_s2    <= sum;
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum = sum + (WP'(pp_s1[i*NB+j]) << (32 * (i + j)));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	assign vld_o  = vld_s2;
	assign side_o = side_s2;
	assign p      = p_s2;

endmodule

FILE: hw/rtl/hvd_to_rad.sv
// ----------------------------------------------------------------------------
// hvd_to_rad
// Degrees to radians in Q40: multiply by pi, then an exact rounded divide by
// 180 (or 360 for a half angle) done as a shift and a reciprocal of 45.
// ----------------------------------------------------------------------------
module hvd_to_rad (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   half,
	input  logic                   vld_i,
	input  logic [hvd_pkg::MW-1:0] mag,
	output logic                   vld_o,
	output logic [hvd_pkg::QW-1:0] rad
);

	localparam int P1W = hvd_pkg::MW + 64;
	localparam int P2W = hvd_pkg::NW + hvd_pkg::RCW;

	logic                   v1;
	logic [P1W-1:0]         p1;
	logic [63:0]            w;
	logic [63:0]            x;
	logic                   vld_s1;
	logic [hvd_pkg::NW-1:0] n_s1;
	logic [P2W-1:0]         p2;

	hvd_mul #(.WA(hvd_pkg::MW), .WB(64), .SW(1)) u_mul_pi (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_i),
		.side_i (1'b0),
		.a      (mag),
		.b      (hvd_pkg::PI_Q62),
		.vld_o  (v1),
		.side_o (),
		.p      (p1)
	);

	// half of the divisor is added before the divide to round to nearest
	always_comb begin
		w = 64'(p1 >> (8 + hvd_pkg::DEG_FRAC_BITS));
		x = w + (half ? 64'd2949120 : 64'd1474560);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= half ? hvd_pkg::NW'(x >> 17) : hvd_pkg::NW'(x >> 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= v1;
		end
	end

	hvd_mul #(.WA(hvd_pkg::NW), .WB(hvd_pkg::RCW), .SW(1)) u_mul_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s1),
		.side_i (1'b0),
		.a      (n_s1),
		.b      (hvd_pkg::RECIP45),
		.vld_o  (vld_o),
		.side_o (),
		.p      (p2)
	);

	assign rad = p2[hvd_pkg::QW+53:54];

endmodule

FILE: hw/rtl/hvd_cordic.sv
// ----------------------------------------------------------------------------
// hvd_cordic
// Pipelined CORDIC, one micro-rotation per stage. Rotation mode steers on the
// sign of z, vectoring mode on the sign of y.
// ----------------------------------------------------------------------------
module hvd_cordic #(
	parameter int ITER = 32,
	parameter int SW   = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vector_mode,
	input  logic          vld_i,
	input  logic [SW-1:0] side_i,
	input  hvd_pkg::cw_t  x_i,
	input  hvd_pkg::cw_t  y_i,
	input  hvd_pkg::cw_t  z_i,
	output logic          vld_o,
	output logic [SW-1:0] side_o,
	output hvd_pkg::cw_t  x_o,
	output hvd_pkg::cw_t  y_o,
	output hvd_pkg::cw_t  z_o
);

	hvd_pkg::cw_t  x_s   [0:ITER];
	hvd_pkg::cw_t  y_s   [0:ITER];
	hvd_pkg::cw_t  z_s   [0:ITER];
	logic          vld_s [0:ITER];
	logic [SW-1:0] side_s[0:ITER];

	assign x_s[0]    = x_i;
	assign y_s[0]    = y_i;
	assign z_s[0]    = z_i;
	assign vld_s[0]  = vld_i;
	assign side_s[0] = side_i;

	for (genvar I = 0; I < ITER; I++) begin : g_step
		localparam hvd_pkg::cw_t AT = hvd_pkg::CW'(hvd_pkg::atan_q40(I));
		hvd_pkg::cw_t dx, dy;
		logic         pos;

		always_comb begin
			dx  = x_s[I] >>> I;
			dy  = y_s[I] >>> I;
			pos = vector_mode ? y_s[I][hvd_pkg::CW-1] : !z_s[I][hvd_pkg::CW-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[I+1] <= side_s[I];
				if (pos) begin
					x_s[I+1] <= x_s[I] - dy;
					y_s[I+1] <= y_s[I] + dx;
					z_s[I+1] <= z_s[I] - AT;
				end else begin
					x_s[I+1] <= x_s[I] + dy;
					y_s[I+1] <= y_s[I] - dx;
					z_s[I+1] <= z_s[I] + AT;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[I+1] <= 1'b0;
			end else if (en) begin
				vld_s[I+1] <= vld_s[I];
			end
		end
	end

	assign x_o    = x_s[ITER];
	assign y_o    = y_s[ITER];
	assign z_o    = z_s[ITER];
	assign vld_o  = vld_s[ITER];
	assign side_o = side_s[ITER];

endmodule

FILE: hw/rtl/hvd_sqrt.sv
// ----------------------------------------------------------------------------
// hvd_sqrt
// Pipelined restoring integer square root, one result bit per stage (floor).
// ----------------------------------------------------------------------------
module hvd_sqrt #(
	parameter int NB = 41
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [2*NB-1:0] v,
	output logic            vld_o,
	output logic [NB-1:0]   root
);

	localparam int RW = NB + 4;

	logic [2*NB-1:0] v_s    [0:NB];
	logic [RW-1:0]   rem_s  [0:NB];
	logic [NB-1:0]   root_s [0:NB];
	logic            vld_s  [0:NB];

	assign v_s[0]    = v;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign vld_s[0]  = vld_i;

	for (genvar K = 0; K < NB; K++) begin : g_bit
		logic [RW-1:0] rsh;
		logic [RW-1:0] trial;
		logic          ge;

		always_comb begin
			rsh   = {rem_s[K][RW-3:0], v_s[K][2*(NB-1-K) +: 2]};
			trial = RW'({root_s[K], 2'b01});
			ge    = rsh >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[K+1]    <= v_s[K];
				rem_s[K+1]  <= ge ? rsh - trial : rsh;
				root_s[K+1] <= {root_s[K][NB-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[K+1] <= 1'b0;
			end else if (en) begin
				vld_s[K+1] <= vld_s[K];
			end
		end
	end

	assign root  = root_s[NB];
	assign vld_o = vld_s[NB];

endmodule

FILE: hw/rtl/haversine_distance.sv
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two points by the haversine formula, in
// millimetres, on a fully pipelined datapath.
//
//   channel  dir  handshake       payload
//   s_*      in   tvalid/tready   s_tdata: two points, magnitudes and flags
//   m_*      out  tvalid/tready   m_tdata: distance_mm
//   APB      in   psel/penable    sphere_radius_m at byte address 0
//
// One item per cycle while the output is taken. The datapath runs through the
// two CORDIC chains and the 41-stage square roots.
// All stages advance together; when the output register holds an item that
// is not taken, the whole pipeline holds and s_tready drops.
// Reset clears valid bits and loads the default radius.
// ----------------------------------------------------------------------------
module haversine_distance #(
	parameter int CORDIC_ITERATIONS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [26:0] first_lat_deg, [27] first_lat_south, [55:28] first_lon_deg,
	// [56] first_lon_west, [83:57] second_lat_deg, [84] second_lat_south,
	// [112:85] second_lon_deg, [113] second_lon_west
	input  logic [119:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [35:0] distance_mm
	output logic [39:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int VW  = hvd_pkg::VW;
	localparam int CW  = hvd_pkg::CW;
	localparam int SQW = hvd_pkg::SQW;
	localparam logic [80:0] ONE_Q80 = 81'd1 << 80;
	localparam logic signed [29:0] LON_S = 30'(hvd_pkg::LON_MAX);

	logic en;

	// ---------------- configuration ----------------
	logic [23:0] radius_q;
	logic [34:0] rk_q;
	logic [34:0] rk_new;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2] == hvd_pkg::REG_RADIUS;
	assign rk_new  = (35'(pwdata[23:0]) << 11) - (35'(pwdata[23:0]) << 5)
		- (35'(pwdata[23:0]) << 4);
	assign prdata  = reg_sel ? {8'd0, radius_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= hvd_pkg::RADIUS_RESET;
			rk_q     <= 35'(hvd_pkg::RADIUS_RESET) * 35'd2000;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			radius_q <= pwdata[23:0];
			rk_q     <= rk_new;
		end
	end

	// ---------------- input: saturate ----------------
	logic [26:0] f_lat1, f_lat2;
	logic [27:0] f_lon1, f_lon2;
	logic [26:0] m0_s1, m2_s1;
	logic [27:0] m1_s1, m3_s1;
	logic        ns1_s1, ws1_s1, ns2_s1, ws2_s1;
	logic        v_s1, v_s2, v_s3;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	assign f_lat1 = s_tdata[26:0];
	assign f_lon1 = s_tdata[55:28];
	assign f_lat2 = s_tdata[83:57];
	assign f_lon2 = s_tdata[112:85];

	always_ff @(posedge clk) begin
		if (en) begin
			m0_s1  <= (f_lat1 > hvd_pkg::LAT_MAX) ? hvd_pkg::LAT_MAX : f_lat1;
			m1_s1  <= (f_lon1 > hvd_pkg::LON_MAX) ? hvd_pkg::LON_MAX : f_lon1;
			m2_s1  <= (f_lat2 > hvd_pkg::LAT_MAX) ? hvd_pkg::LAT_MAX : f_lat2;
			m3_s1  <= (f_lon2 > hvd_pkg::LON_MAX) ? hvd_pkg::LON_MAX : f_lon2;
			ns1_s1 <= s_tdata[27];
			ws1_s1 <= s_tdata[56];
			ns2_s1 <= s_tdata[84];
			ws2_s1 <= s_tdata[113];
		end
	end

	// ---------------- signed differences ----------------
	logic signed [28:0] lat1, lat2, lon1, lon2;
	logic signed [28:0] dlat_s2;
	logic signed [29:0] dlon_s2;
	logic [26:0]        m0_s2, m2_s2;

	always_comb begin
		lat1 = ns1_s1 ? -29'(m0_s1) : 29'(m0_s1);
		lat2 = ns2_s1 ? -29'(m2_s1) : 29'(m2_s1);
		lon1 = ws1_s1 ? -29'(m1_s1) : 29'(m1_s1);
		lon2 = ws2_s1 ? -29'(m3_s1) : 29'(m3_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s2 <= lat2 - lat1;
			dlon_s2 <= 30'(lon2) - 30'(lon1);
			m0_s2   <= m0_s1;
			m2_s2   <= m2_s1;
		end
	end

	// ---------------- wrap and magnitude ----------------
	logic signed [29:0] dlon_w;
	logic [27:0]        dlat_abs_s3, dlon_abs_s3;
	logic [27:0]        m0_s3, m2_s3;

	always_comb begin
		dlon_w = dlon_s2;
		if (dlon_s2 > LON_S) begin
			dlon_w = dlon_s2 - (LON_S <<< 1);
		end else if (dlon_s2 < -LON_S) begin
			dlon_w = dlon_s2 + (LON_S <<< 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_abs_s3 <= dlat_s2[28] ? 28'(-dlat_s2) : 28'(dlat_s2);
			dlon_abs_s3 <= dlon_w[29] ? 28'(-dlon_w) : 28'(dlon_w);
			m0_s3       <= 28'(m0_s2);
			m2_s3       <= 28'(m2_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// ---------------- radians ----------------
	logic                   vr;
	logic [hvd_pkg::QW-1:0] r_lat1, r_lat2, r_dlat, r_dlon;

	hvd_to_rad u_rad_lat1 (.clk(clk), .arst_n(arst_n), .en(en), .half(1'b0),
		.vld_i(v_s3), .mag(m0_s3), .vld_o(vr), .rad(r_lat1));
	hvd_to_rad u_rad_lat2 (.clk(clk), .arst_n(arst_n), .en(en), .half(1'b0),
		.vld_i(v_s3), .mag(m2_s3), .vld_o(), .rad(r_lat2));
	hvd_to_rad u_rad_dlat (.clk(clk), .arst_n(arst_n), .en(en), .half(1'b1),
		.vld_i(v_s3), .mag(dlat_abs_s3), .vld_o(), .rad(r_dlat));
	hvd_to_rad u_rad_dlon (.clk(clk), .arst_n(arst_n), .en(en), .half(1'b1),
		.vld_i(v_s3), .mag(dlon_abs_s3), .vld_o(), .rad(r_dlon));

	// ---------------- sine and cosine ----------------
	localparam hvd_pkg::cw_t GAIN = CW'(hvd_pkg::GAIN_Q40);

	logic         vc;
	hvd_pkg::cw_t xc_lat1, xc_lat2, ys_dlat, ys_dlon;

	hvd_cordic #(.ITER(CORDIC_ITERATIONS), .SW(1)) u_cs_lat1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vector_mode(1'b0),
		.vld_i(vr), .side_i(1'b0), .x_i(GAIN), .y_i('0), .z_i(CW'(r_lat1)),
		.vld_o(vc), .side_o(), .x_o(xc_lat1), .y_o(), .z_o());
	hvd_cordic #(.ITER(CORDIC_ITERATIONS), .SW(1)) u_cs_lat2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vector_mode(1'b0),
		.vld_i(vr), .side_i(1'b0), .x_i(GAIN), .y_i('0), .z_i(CW'(r_lat2)),
		.vld_o(), .side_o(), .x_o(xc_lat2), .y_o(), .z_o());
	hvd_cordic #(.ITER(CORDIC_ITERATIONS), .SW(1)) u_cs_dlat (
		.clk(clk), .arst_n(arst_n), .en(en), .vector_mode(1'b0),
		.vld_i(vr), .side_i(1'b0), .x_i(GAIN), .y_i('0), .z_i(CW'(r_dlat)),
		.vld_o(), .side_o(), .x_o(), .y_o(ys_dlat), .z_o());
	hvd_cordic #(.ITER(CORDIC_ITERATIONS), .SW(1)) u_cs_dlon (
		.clk(clk), .arst_n(arst_n), .en(en), .vector_mode(1'b0),
		.vld_i(vr), .side_i(1'b0), .x_i(GAIN), .y_i('0), .z_i(CW'(r_dlon)),
		.vld_o(), .side_o(), .x_o(), .y_o(ys_dlon), .z_o());

	// drop slightly negative outputs to zero
	logic          v_s4;
	logic [VW-1:0] ca_s4, cb_s4, a_s4, b_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ca_s4 <= xc_lat1[CW-1] ? '0 : VW'(xc_lat1);
			cb_s4 <= xc_lat2[CW-1] ? '0 : VW'(xc_lat2);
			a_s4  <= ys_dlat[CW-1] ? '0 : VW'(ys_dlat);
			b_s4  <= ys_dlon[CW-1] ? '0 : VW'(ys_dlon);
		end
	end

	// ---------------- haversine term ----------------
	logic          va;
	logic [83:0]   pa, pa2;
	logic [VW-1:0] b_a;

	hvd_mul #(.WA(VW), .WB(VW), .SW(VW)) u_mul_cc (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(v_s4), .side_i(b_s4),
		.a(ca_s4), .b(cb_s4), .vld_o(va), .side_o(b_a), .p(pa));
	hvd_mul #(.WA(VW), .WB(VW), .SW(1)) u_mul_aa (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(v_s4), .side_i(1'b0),
		.a(a_s4), .b(a_s4), .vld_o(), .side_o(), .p(pa2));

	logic          v_s5;
	logic [83:0]   ga_r;
	logic [43:0]   g_s5;
	logic [VW-1:0] b_s5;
	logic [83:0]   a2_s5;

	assign ga_r = pa + (84'd1 << 39);

	always_ff @(posedge clk) begin
		if (en) begin
			g_s5  <= ga_r[83:40];
			b_s5  <= b_a;
			a2_s5 <= pa2;
		end
	end

	logic              vb;
	logic [85:0]       pb;
	logic [VW+83:0]    sb;

	hvd_mul #(.WA(44), .WB(VW), .SW(VW+84)) u_mul_gb (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(v_s5), .side_i({a2_s5, b_s5}),
		.a(g_s5), .b(b_s5), .vld_o(vb), .side_o(sb), .p(pb));

	logic          v_s6;
	logic [85:0]   tb_r;
	logic [45:0]   t_s6;
	logic [VW-1:0] b_s6;
	logic [83:0]   a2_s6;

	assign tb_r = pb + (86'd1 << 39);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s6  <= tb_r[85:40];
			b_s6  <= sb[VW-1:0];
			a2_s6 <= sb[VW+83:VW];
		end
	end

	logic        vt;
	logic [87:0] pc;
	logic [83:0] a2_c;

	hvd_mul #(.WA(46), .WB(VW), .SW(84)) u_mul_tb (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(v_s6), .side_i(a2_s6),
		.a(t_s6), .b(b_s6), .vld_o(vt), .side_o(a2_c), .p(pc));

	logic        v_s7;
	logic [88:0] h_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			h_s7 <= 89'(a2_c) + 89'(pc);
		end
	end

	// clamp to one and form the complement
	logic        v_s8;
	logic [80:0] hc, hc_s8, om_s8;

	assign hc = (h_s7 >= 89'(ONE_Q80)) ? ONE_Q80 : h_s7[80:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hc_s8 <= hc;
			om_s8 <= ONE_Q80 - hc;
		end
	end

	// ---------------- roots and arctangent ----------------
	logic           vq;
	logic [SQW-1:0] sq_s, sq_c;

	hvd_sqrt #(.NB(SQW)) u_sqrt_h (.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(v_s8), .v({1'b0, hc_s8}), .vld_o(vq), .root(sq_s));
	hvd_sqrt #(.NB(SQW)) u_sqrt_c (.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(v_s8), .v({1'b0, om_s8}), .vld_o(), .root(sq_c));

	logic         vz;
	logic         zr;
	hvd_pkg::cw_t z_at;

	hvd_cordic #(.ITER(CORDIC_ITERATIONS), .SW(1)) u_atan (
		.clk(clk), .arst_n(arst_n), .en(en), .vector_mode(1'b1),
		.vld_i(vq), .side_i(sq_s == '0), .x_i(CW'(sq_c)), .y_i(CW'(sq_s)),
		.z_i('0), .vld_o(vz), .side_o(zr), .x_o(), .y_o(), .z_o(z_at));

	logic        v_s9;
	logic [40:0] ang_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s9 <= (zr || z_at[CW-1]) ? '0 : z_at[40:0];
		end
	end

	// ---------------- scale by radius ----------------
	logic        vd;
	logic [75:0] pd;
	logic [75:0] pd_r;
	logic [35:0] dist_q;
	logic        out_vld_q;

	hvd_mul #(.WA(41), .WB(35), .SW(1)) u_mul_r (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(v_s9), .side_i(1'b0),
		.a(ang_s9), .b(rk_q), .vld_o(vd), .side_o(), .p(pd));

	assign pd_r = pd + (76'd1 << 39);

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q <= pd_r[75:40];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_s4      <= vc;
			v_s5      <= va;
			v_s6      <= vb;
			v_s7      <= vt;
			v_s8      <= v_s7;
			v_s9      <= vz;
			out_vld_q <= vd;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, dist_q};

	// ---------------- assertions ----------------
	a_h_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> hc_s8 <= ONE_Q80)
		else $error("haversine term above one after clamp");

	a_h_complement: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> (hc_s8 + om_s8) == ONE_Q80)
		else $error("root operands do not sum to one");

	a_radius_scale: assert property (@(posedge clk) disable iff (!arst_n)
		rk_q == 35'(radius_q) * 35'd2000)
		else $error("scaled radius out of step with radius register");

	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vz && zr) |=> ang_s9 == '0)
		else $error("zero root gave a nonzero angle");

endmodule
